>>> rtl/core/uoc_pkg.sv
// Package for the UTF-8 overlong canonicaliser: payload types, the op record
// between front and back, lead decoding and byte encoding functions.
// No dependencies.
`default_nettype none

package uoc_pkg;

  localparam int unsigned UOC_OPQ_DEPTH = 2;
  localparam int unsigned UOC_CP_W      = 31;
  localparam int unsigned UOC_HELD_N    = 4;

  localparam logic [7:0] UOC_LEAD_MIN  = 8'hC0;
  localparam logic [7:0] UOC_LEAD3_MIN = 8'hE0;
  localparam logic [7:0] UOC_LEAD4_MIN = 8'hF0;
  localparam logic [7:0] UOC_LEAD5_MIN = 8'hF8;
  localparam logic [7:0] UOC_LEAD6_MIN = 8'hFC;
  localparam logic [1:0] UOC_CONT_TAG  = 2'b10;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_final;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       message_end;
  } out_t;

  typedef struct packed {
    logic [UOC_CP_W-1:0] cp;
    logic                last;
    logic                fin;
  } op_t;

  typedef enum logic {
    FS_IDLE,
    FS_FLUSH
  } front_state_t;

  typedef struct packed {
    logic [2:0]          need;
    logic [UOC_CP_W-1:0] acc;
  } lead_info_t;

  function automatic lead_info_t lead_decode(input logic [7:0] b);
    lead_info_t li;
    li = '0;
    if (b < UOC_LEAD3_MIN) begin
      li.need = 3'd1;
      li.acc  = {26'b0, b[4:0]};
    end else if (b < UOC_LEAD4_MIN) begin
      li.need = 3'd2;
      li.acc  = {27'b0, b[3:0]};
    end else if (b < UOC_LEAD5_MIN) begin
      li.need = 3'd3;
      li.acc  = {28'b0, b[2:0]};
    end else if (b < UOC_LEAD6_MIN) begin
      li.need = 3'd4;
      li.acc  = {29'b0, b[1:0]};
    end else begin
      li.need = 3'd5;
      li.acc  = {30'b0, b[0]};
    end
    return li;
  endfunction

  // index of the top six-bit group: encoded length minus one
  function automatic logic [2:0] cp_top(input logic [UOC_CP_W-1:0] cp);
    logic [2:0] j;
    if (cp < 31'h80) begin
      j = 3'd0;
    end else if (cp < 31'h800) begin
      j = 3'd1;
    end else if (cp < 31'h10000) begin
      j = 3'd2;
    end else if (cp < 31'h200000) begin
      j = 3'd3;
    end else if (cp < 31'h4000000) begin
      j = 3'd4;
    end else begin
      j = 3'd5;
    end
    return j;
  endfunction

  function automatic logic [7:0] lead_byte(input logic [UOC_CP_W-1:0] cp,
                                           input logic [2:0] j);
    logic [7:0] r;
    case (j)
      3'd0:    r = cp[7:0];
      3'd1:    r = 8'hC0 | {3'b0, cp[10:6]};
      3'd2:    r = 8'hE0 | {4'b0, cp[15:12]};
      3'd3:    r = 8'hF0 | {5'b0, cp[20:18]};
      3'd4:    r = 8'hF8 | {6'b0, cp[25:24]};
      3'd5:    r = 8'hFC | {7'b0, cp[30]};
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] cont_byte(input logic [UOC_CP_W-1:0] cp,
                                           input logic [2:0] j);
    logic [7:0] r;
    case (j)
      3'd0:    r = {UOC_CONT_TAG, cp[5:0]};
      3'd1:    r = {UOC_CONT_TAG, cp[11:6]};
      3'd2:    r = {UOC_CONT_TAG, cp[17:12]};
      3'd3:    r = {UOC_CONT_TAG, cp[23:18]};
      3'd4:    r = {UOC_CONT_TAG, cp[29:24]};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/uoc_front.sv
// Front of the canonicaliser: accepts raw bytes, tracks the pending sequence
// and pushes one code point op per cycle to the op queue while not full. Uses uoc_pkg.
`default_nettype none

module uoc_front import uoc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire in_t  in_data,
  output logic      full,
  input  wire logic q_full,
  output logic      q_push,
  output op_t       q_op
);

  front_state_t        st_r, st_nxt;
  logic [7:0]          lead_r, lead_nxt;
  logic [2:0]          need_r, need_nxt;
  logic [2:0]          seen_r, seen_nxt;
  logic [UOC_CP_W-1:0] acc_r, acc_nxt;
  logic [7:0]          held_r [UOC_HELD_N];
  logic [2:0]          fl_idx_r, fl_idx_nxt;
  logic [2:0]          fl_cnt_r, fl_cnt_nxt;
  logic [7:0]          tail_r, tail_nxt;
  logic                tail_en_r, tail_en_nxt;
  logic                fin_r, fin_nxt;

  logic                accept, pend, is_cont, cont_done, fresh_emit, go_flush;
  logic                fl_more, fl_last, held_we;
  logic [7:0]          b;
  logic                f;
  logic [UOC_CP_W-1:0] acc_new;
  lead_info_t          li;

  assign b          = in_data.in_byte;
  assign f          = in_data.in_final;
  assign full       = (st_r != FS_IDLE) || q_full;
  assign accept     = push && !full;
  assign pend       = (need_r != 3'd0);
  assign is_cont    = (b[7:6] == UOC_CONT_TAG);
  assign cont_done  = ({1'b0, seen_r} + 4'd1) >= {1'b0, need_r};
  assign fresh_emit = (b < UOC_LEAD_MIN) || f;
  assign go_flush   = pend && (is_cont ? (!cont_done && f)
                                       : ((seen_r != 3'd0) || fresh_emit));
  assign acc_new    = {acc_r[UOC_CP_W-7:0], b[5:0]};
  assign li         = lead_decode(b);
  assign held_we    = accept && pend && is_cont && !cont_done;
  assign fl_more    = (fl_idx_r < fl_cnt_r);
  assign fl_last    = fl_more ? ((3'(fl_idx_r + 3'd1) == fl_cnt_r) && !tail_en_r) : 1'b1;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      FS_IDLE: begin
        if (accept && go_flush) st_nxt = FS_FLUSH;
      end
      FS_FLUSH: begin
        if (!q_full && fl_last) st_nxt = FS_IDLE;
      end
      default: st_nxt = FS_IDLE;
    endcase
  end

  always_comb begin
    lead_nxt    = lead_r;
    need_nxt    = need_r;
    seen_nxt    = seen_r;
    acc_nxt     = acc_r;
    fl_idx_nxt  = fl_idx_r;
    fl_cnt_nxt  = fl_cnt_r;
    tail_nxt    = tail_r;
    tail_en_nxt = tail_en_r;
    fin_nxt     = fin_r;
    q_push      = 1'b0;
    q_op        = '0;
    case (st_r)
      FS_IDLE: begin
        if (accept) begin
          q_op.fin = f;
          if (!pend) begin
            if (fresh_emit) begin
              q_push     = 1'b1;
              q_op.cp    = {23'b0, b};
              q_op.last  = 1'b1;
            end else begin
              lead_nxt = b;
              need_nxt = li.need;
              seen_nxt = 3'd0;
              acc_nxt  = li.acc;
            end
          end else if (is_cont) begin
            if (cont_done) begin
              q_push    = 1'b1;
              q_op.cp   = acc_new;
              q_op.last = 1'b1;
              need_nxt  = 3'd0;
              seen_nxt  = 3'd0;
            end else begin
              acc_nxt  = acc_new;
              seen_nxt = 3'(seen_r + 3'd1);
              if (f) begin
                q_push      = 1'b1;
                q_op.cp     = {23'b0, lead_r};
                q_op.last   = 1'b0;
                need_nxt    = 3'd0;
                seen_nxt    = 3'd0;
                fl_idx_nxt  = 3'd0;
                fl_cnt_nxt  = 3'(seen_r + 3'd1);
                tail_en_nxt = 1'b0;
                fin_nxt     = 1'b1;
              end
            end
          end else begin
            // broken sequence: flush lead now, held bytes and an emitted breaker follow
            q_push      = 1'b1;
            q_op.cp     = {23'b0, lead_r};
            q_op.last   = (seen_r == 3'd0) && !fresh_emit;
            fl_idx_nxt  = 3'd0;
            fl_cnt_nxt  = seen_r;
            tail_nxt    = b;
            tail_en_nxt = fresh_emit;
            fin_nxt     = f;
            if (fresh_emit) begin
              need_nxt = 3'd0;
              seen_nxt = 3'd0;
            end else begin
              lead_nxt = b;
              need_nxt = li.need;
              seen_nxt = 3'd0;
              acc_nxt  = li.acc;
            end
          end
        end
      end
      FS_FLUSH: begin
        if (!q_full) begin
          q_push    = 1'b1;
          q_op.cp   = fl_more ? {23'b0, held_r[fl_idx_r[1:0]]} : {23'b0, tail_r};
          q_op.last = fl_last;
          q_op.fin  = fin_r;
          if (fl_more) fl_idx_nxt = 3'(fl_idx_r + 3'd1);
        end
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= FS_IDLE;
      need_r <= 3'd0;
      seen_r <= 3'd0;
    end else begin
      st_r   <= st_nxt;
      need_r <= need_nxt;
      seen_r <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lead_r    <= lead_nxt;
    acc_r     <= acc_nxt;
    fl_idx_r  <= fl_idx_nxt;
    fl_cnt_r  <= fl_cnt_nxt;
    tail_r    <= tail_nxt;
    tail_en_r <= tail_en_nxt;
    fin_r     <= fin_nxt;
    if (held_we) held_r[seen_r[1:0]] <= b;
  end

endmodule

`default_nettype wire

>>> rtl/core/uoc_opq.sv
// Op queue between front and back of the canonicaliser.
// Holds op_t records from uoc_pkg; depth set by parameter.
`default_nettype none

module uoc_opq import uoc_pkg::*; #(
  parameter int unsigned DEPTH = UOC_OPQ_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_en,
  input  wire op_t  wr_op,
  output logic      full,
  input  wire logic rd_en,
  output op_t       rd_op,
  output logic      empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  op_t           mem [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign rd_op = mem[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : AW'(wp_r + 1'b1);
    if (do_rd) rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : AW'(rp_r + 1'b1);
    if (do_wr && !do_rd) cnt_nxt = CW'(cnt_r + 1'b1);
    else if (do_rd && !do_wr) cnt_nxt = CW'(cnt_r - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wp_r] <= wr_op;
  end

endmodule

`default_nettype wire

>>> rtl/core/uoc_back.sv
// Back of the canonicaliser: takes code point ops from the queue and emits
// their shortest encoding through an output register, one byte per cycle
// while that register is free or popped. Uses uoc_pkg.
`default_nettype none

module uoc_back import uoc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_empty,
  input  wire op_t  q_op,
  output logic      q_pop,
  input  wire logic pop,
  output logic      empty,
  output out_t      out_data
);

  logic                cur_vld_r, cur_vld_nxt;
  logic [UOC_CP_W-1:0] cp_r, cp_nxt;
  logic [2:0]          j_r, j_nxt;
  logic                lead_r, lead_nxt;
  logic                last_r, last_nxt;
  logic                fin_r, fin_nxt;
  out_t                out_r, out_nxt;
  logic                out_vld_r, out_vld_nxt;

  logic                out_free, step, op_done;
  logic [7:0]          byte_c;

  assign empty    = !out_vld_r;
  assign out_data = out_r;
  assign out_free = !out_vld_r || pop;
  assign step     = cur_vld_r && out_free;
  assign op_done  = step && (j_r == 3'd0);
  assign q_pop    = !q_empty && (!cur_vld_r || op_done);
  assign byte_c   = lead_r ? lead_byte(cp_r, j_r) : cont_byte(cp_r, j_r);

  always_comb begin
    out_nxt     = out_r;
    out_vld_nxt = out_vld_r;
    cur_vld_nxt = cur_vld_r;
    cp_nxt      = cp_r;
    j_nxt       = j_r;
    lead_nxt    = lead_r;
    last_nxt    = last_r;
    fin_nxt     = fin_r;
    if (step) begin
      out_vld_nxt          = 1'b1;
      out_nxt.out_byte     = byte_c;
      out_nxt.run_last     = last_r && (j_r == 3'd0);
      out_nxt.message_end  = fin_r && last_r && (j_r == 3'd0);
      lead_nxt             = 1'b0;
      j_nxt                = 3'(j_r - 3'd1);
      if (op_done) cur_vld_nxt = 1'b0;
    end else if (pop) begin
      out_vld_nxt = 1'b0;
    end
    if (q_pop) begin
      cur_vld_nxt = 1'b1;
      cp_nxt      = q_op.cp;
      j_nxt       = cp_top(q_op.cp);
      lead_nxt    = 1'b1;
      last_nxt    = q_op.last;
      fin_nxt     = q_op.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      cur_vld_r <= cur_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cp_r   <= cp_nxt;
    j_r    <= j_nxt;
    lead_r <= lead_nxt;
    last_r <= last_nxt;
    fin_r  <= fin_nxt;
    out_r  <= out_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/core/utf8_overlong_canonicalizer_top.sv
// Top level of the UTF-8 overlong canonicaliser: front, op queue and back.
// Depends on uoc_pkg, uoc_front, uoc_opq and uoc_back.
//
//   channel | ports                    | accepted when
//   input   | push, full, in_data      | push && !full
//   result  | empty, pop, out_data     | pop && !empty
//
// A byte is taken when no flush is due and the op queue has room.
// A broken sequence keeps the front busy while it flushes held continuations,
// then a breaking byte that is emitted rather than held as a new lead;
// a sequence cut by the final byte is flushed likewise, each held continuation
// and that byte included. The back emits one output byte per cycle while its
// output register is free or being popped. Reset is synchronous and empties
// the queue, the output register and any pending sequence.
`default_nettype none

module utf8_overlong_canonicalizer_top import uoc_pkg::*; #(
  parameter int unsigned OPQ_DEPTH = UOC_OPQ_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  output logic      full,
  input  wire in_t  in_data,
  output logic      empty,
  input  wire logic pop,
  output out_t      out_data
);

  logic q_full, q_empty, q_push, q_pop;
  op_t  q_wr_op, q_rd_op;

  uoc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .in_data (in_data),
    .full    (full),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_op    (q_wr_op)
  );

  uoc_opq #(
    .DEPTH (OPQ_DEPTH)
  ) u_opq (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (q_push),
    .wr_op (q_wr_op),
    .full  (q_full),
    .rd_en (q_pop),
    .rd_op (q_rd_op),
    .empty (q_empty)
  );

  uoc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_op     (q_rd_op),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

>>> rtl/core/uoc_chk.sv
// Port checker for the UTF-8 overlong canonicaliser top level, with its bind.
// Depends on uoc_pkg.
`default_nettype none

module uoc_chk import uoc_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic full,
  input wire logic empty,
  input wire logic pop,
  input wire out_t out_data
);

  a_empty_after_reset: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result side not empty after reset");

  a_ready_after_reset: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("input side full after reset");

  a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.message_end) |-> out_data.run_last)
    else $error("message end without run end");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("waiting result changed or dropped");

endmodule

bind utf8_overlong_canonicalizer_top uoc_chk u_chk (.*);

`default_nettype wire
